FILE: hw/rtl/lirs_pkg.sv
// Shared types and constants for the linear interpolation resampler.
package lirs_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StepW   = 34;
  localparam int unsigned PhaseW  = 35;
  localparam int unsigned DeltaW  = SampleW + 1;
  localparam int unsigned CntW    = 2;

  // 1.0 in Q32, carried at the accumulator width.
  localparam logic [PhaseW-1:0] ONE_Q32 = PhaseW'(64'd1 << 32);
  // Last result slot that a frame may use before the run is cut off.
  localparam logic [CntW-1:0] LAST_SLOT = CntW'(3);

  localparam logic CFG_PHASE_STEP  = 1'b0;
  localparam logic CFG_STEREO_MODE = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic                      last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_EMIT,
    S_FIN
  } state_t;

endpackage

FILE: hw/rtl/linear_interp_resampler_unit.sv
// Top level of the linear interpolation resampler: sequencer, state and handshakes.
// A first frame after reset or a phase_step write is passed through S_START to the output register.
// A later frame that yields k words (1 to 4) runs S_MUL and S_EMIT once per word, and one that
// yields none only S_MUL; both end in S_FIN. The multiplier and phase adder are shared by all words.
// Results leave through an output register, so a frame may be accepted while the last word
// of the previous one is still stalled. Reset (synchronous, active low) sets phase_step to 1.0,
// mono mode, and clears the started flag, the previous sample and the phase accumulator.
module linear_interp_resampler_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lirs_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lirs_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [lirs_pkg::StepW-1:0]          cfg_data
);

  // Configuration registers.
  logic [lirs_pkg::StepW-1:0]  step_r;
  logic                        stereo_r;

  // Converter state.
  lirs_pkg::state_t                    state_r, state_nxt;
  logic                                started_r, started_nxt;
  logic signed [lirs_pkg::SampleW-1:0] prev_r, prev_nxt;
  logic signed [lirs_pkg::SampleW-1:0] cur_r, cur_nxt;
  logic [lirs_pkg::PhaseW-1:0]         phase_r, phase_nxt;
  logic [lirs_pkg::CntW-1:0]           cnt_r, cnt_nxt;

  // Output register.
  logic                                out_valid_r, out_valid_nxt;
  lirs_pkg::out_word_t                 out_word_r, out_word_nxt;

  logic                                in_take;
  logic                                slot_free;
  logic signed [lirs_pkg::SampleW:0]   lr_sum;
  logic signed [lirs_pkg::SampleW:0]   lr_sum_adj;
  logic signed [lirs_pkg::SampleW-1:0] frame_val;
  logic [lirs_pkg::PhaseW-1:0]         eff_step;
  logic [lirs_pkg::PhaseW-1:0]         add_b;
  logic [lirs_pkg::PhaseW-1:0]         add_sum;
  logic signed [lirs_pkg::DeltaW-1:0]  delta;
  logic signed [lirs_pkg::SampleW-1:0] scaled;
  logic                                mul_en;

  assign in_stall  = (state_r != lirs_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Stereo downmix: the sum is halved with truncation toward zero, so a negative
  // sum is bumped by one before the arithmetic shift.
  assign lr_sum     = {in_word.left_sample[lirs_pkg::SampleW-1], in_word.left_sample}
                    + {in_word.right_sample[lirs_pkg::SampleW-1], in_word.right_sample};
  assign lr_sum_adj = lr_sum + {{lirs_pkg::SampleW{1'b0}}, lr_sum[lirs_pkg::SampleW]};
  assign frame_val  = stereo_r ? lr_sum_adj[lirs_pkg::SampleW:1] : in_word.left_sample;

  // A zero step behaves as the smallest Q32 step.
  assign eff_step = (step_r == '0) ? lirs_pkg::PhaseW'(1) : {1'b0, step_r};

  // The one phase adder: advances by the step while emitting, and takes 1.0 off
  // when the frame is finished.
  assign add_b   = (state_r == lirs_pkg::S_FIN) ? (~lirs_pkg::ONE_Q32 + lirs_pkg::PhaseW'(1))
                                                : eff_step;
  assign add_sum = phase_r + add_b;

  assign delta  = {cur_r[lirs_pkg::SampleW-1], cur_r} - {prev_r[lirs_pkg::SampleW-1], prev_r};
  assign mul_en = (state_r == lirs_pkg::S_MUL) && (phase_r <= lirs_pkg::ONE_Q32);

  lirs_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .delta  (delta),
    .phase  (phase_r[32:0]),
    .scaled (scaled)
  );

  // Sequencer: one frame at a time; each word passes through a multiply state and an emit state.
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    case (state_r)
      lirs_pkg::S_IDLE: begin
        if (in_take) begin
          cur_nxt   = frame_val;
          cnt_nxt   = '0;
          state_nxt = started_r ? lirs_pkg::S_MUL : lirs_pkg::S_START;
        end
      end
      lirs_pkg::S_START: begin
        // The first frame goes straight through and primes the phase with the step.
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.out_sample  = cur_r;
          out_word_nxt.last_of_run = 1'b1;
          prev_nxt                 = cur_r;
          phase_nxt                = eff_step;
          started_nxt              = 1'b1;
          state_nxt                = lirs_pkg::S_IDLE;
        end
      end
      lirs_pkg::S_MUL: begin
        // Only reached with phase above 1.0 when the frame yields no word at all.
        state_nxt = (phase_r <= lirs_pkg::ONE_Q32) ? lirs_pkg::S_EMIT : lirs_pkg::S_FIN;
      end
      lirs_pkg::S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.out_sample  = prev_r + scaled;
          out_word_nxt.last_of_run = (add_sum > lirs_pkg::ONE_Q32) ||
                                     (cnt_r == lirs_pkg::LAST_SLOT);
          phase_nxt                = add_sum;
          cnt_nxt                  = cnt_r + lirs_pkg::CntW'(1);
          state_nxt                = out_word_nxt.last_of_run ? lirs_pkg::S_FIN
                                                              : lirs_pkg::S_MUL;
        end
      end
      lirs_pkg::S_FIN: begin
        // When the word cap stopped the run at or below 1.0, the phase floors at zero.
        phase_nxt = (phase_r > lirs_pkg::ONE_Q32) ? {1'b0, add_sum[lirs_pkg::StepW-1:0]} : '0;
        prev_nxt  = cur_r;
        state_nxt = lirs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lirs_pkg::S_IDLE;
      end
    endcase

    // A step write restarts the converter; the user must write it only while the block is idle (not enforced here).
    if (cfg_we && (cfg_index == lirs_pkg::CFG_PHASE_STEP)) begin
      started_nxt = 1'b0;
      prev_nxt    = '0;
      phase_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lirs_pkg::S_IDLE;
      started_r   <= 1'b0;
      prev_r      <= '0;
      phase_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= lirs_pkg::StepW'(64'd1 << 32);
      stereo_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      prev_r      <= prev_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == lirs_pkg::CFG_PHASE_STEP) begin
          step_r <= cfg_data;
        end else begin
          stereo_r <= cfg_data[0];
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A word is only interpolated while the phase lies within the current interval.
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lirs_pkg::S_EMIT) |-> (phase_r <= lirs_pkg::ONE_Q32))
    else $error("emit with phase above 1.0");

  // An accepted frame goes either to the pass-through step or to the multiply step.
  a_take_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == lirs_pkg::S_START || state_r == lirs_pkg::S_MUL))
    else $error("frame accepted without starting work");

  // Before the first frame the phase accumulator stays cleared.
  a_unstarted_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (!started_r && state_r == lirs_pkg::S_IDLE) |-> (phase_r == '0))
    else $error("phase nonzero before first frame");

  // A flagged word always ends the frame's run.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lirs_pkg::S_EMIT && slot_free && out_word_nxt.last_of_run)
      |=> (state_r == lirs_pkg::S_FIN))
    else $error("last word did not finish the frame");

endmodule

FILE: hw/rtl/lirs_mul.sv
// Registered signed-by-Q32 multiplier that returns the floored interpolation offset.
module lirs_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [lirs_pkg::DeltaW-1:0]   delta,
  input  logic        [32:0]                   phase,
  output logic signed [lirs_pkg::SampleW-1:0]  scaled
);

  logic signed [50:0]                  prod;
  logic signed [lirs_pkg::SampleW-1:0] scaled_r;

  // Taking the upper bits of a two's complement product is a floor by 2^32.
  assign prod = $signed({{34{delta[lirs_pkg::DeltaW-1]}}, delta}) * $signed({18'b0, phase});

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= prod[47:32];
    end
  end

  assign scaled = scaled_r;

endmodule

FILE: verif/tb_linear_interp_resampler_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the linear interpolation resampler unit.
module tb_linear_interp_resampler_unit;

  // 1.0 in Q32 and the mask that keeps a step or a phase within its 34 bits.
  localparam longint unsigned OneQ32   = 64'd1 << 32;
  localparam longint unsigned StepMask = (64'd1 << lirs_pkg::StepW) - 64'd1;
  // The step range that software is expected to program.
  localparam longint unsigned StepLow  = 64'd1431655765;
  localparam longint unsigned StepHigh = 64'd8589934592;
  // A frame never produces more than this many interpolated words.
  localparam int MaxWordsPerFrame = 4;
  // A frame that yields no word still keeps the sequencer busy in its multiply
  // and finish states, so we let this many cycles pass before touching the registers.
  localparam int SettleCycles = 16;
  localparam int CycleLimit = 300000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  lirs_pkg::in_word_t            in_word = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lirs_pkg::out_word_t           out_word;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = lirs_pkg::CFG_PHASE_STEP;
  logic [lirs_pkg::StepW-1:0]    cfg_data = '0;

  // Shadow copy of the converter: registers and running state.
  longint unsigned shadow_step;
  bit              shadow_stereo;
  bit              shadow_started;
  int              shadow_prev;
  longint unsigned shadow_phase;

  // Interpolated words that the block still owes us, oldest first.
  lirs_pkg::out_word_t expected_words[$];
  lirs_pkg::out_word_t head_word;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  linear_interp_resampler_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Works out the words that one accepted frame must produce and queues them.
  // The shift of delta * phase is a flooring one, so negative slopes round
  // down, and the stereo average truncates toward zero like C division.
  task automatic predict_frame(input lirs_pkg::in_word_t w);
    int                  cur;
    int                  delta;
    longint              prod;
    longint unsigned     step;
    int                  n;
    lirs_pkg::out_word_t o;
    step = (shadow_step == 0) ? 64'd1 : shadow_step;
    if (shadow_stereo) begin
      cur = (int'($signed(w.left_sample)) + int'($signed(w.right_sample))) / 2;
    end else begin
      cur = int'($signed(w.left_sample));
    end
    if (!shadow_started) begin
      // The first frame after a restart goes straight through.
      shadow_started = 1'b1;
      shadow_prev = cur;
      shadow_phase = step;
      o.out_sample = lirs_pkg::SampleW'(cur);
      o.last_of_run = 1'b1;
      expected_words.push_back(o);
    end else begin
      n = 0;
      while (shadow_phase <= OneQ32 && n < MaxWordsPerFrame) begin
        delta = cur - shadow_prev;
        prod = longint'(delta) * longint'(shadow_phase);
        o.out_sample = lirs_pkg::SampleW'(shadow_prev + int'(prod >>> 32));
        o.last_of_run = 1'b0;
        expected_words.push_back(o);
        n++;
        shadow_phase += step;
      end
      if (n > 0) begin
        o = expected_words.pop_back();
        o.last_of_run = 1'b1;
        expected_words.push_back(o);
      end
      // When the word cap cut the run short, the phase clamps at zero.
      shadow_phase = (shadow_phase > OneQ32) ? ((shadow_phase - OneQ32) & StepMask) : 64'd0;
      shadow_prev = cur;
    end
  endtask

  // Offers one frame, with random idle cycles ahead of it, and holds it until
  // the block takes it. Valid is left high so back-to-back frames stay packed.
  task automatic send_frame(input lirs_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_frame(w);
  endtask

  // Stops sending and waits until every owed word has arrived, then lets the
  // sequencer finish any frame that produced no word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic idx, input longint unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= lirs_pkg::StepW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == lirs_pkg::CFG_PHASE_STEP) begin
      // A new step restarts the converter from scratch.
      shadow_step = value & StepMask;
      shadow_started = 1'b0;
      shadow_prev = 0;
      shadow_phase = 64'd0;
    end else begin
      shadow_stereo = value[0];
    end
  endtask

  function automatic lirs_pkg::in_word_t make_frame(input int left, input int right);
    lirs_pkg::in_word_t w;
    w.left_sample = lirs_pkg::SampleW'(left);
    w.right_sample = lirs_pkg::SampleW'(right);
    return w;
  endfunction

  // Every word the block hands over is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_sample %0d, last_of_run %0b",
               out_word.out_sample, out_word.last_of_run);
        error_count++;
      end else begin
        head_word = expected_words.pop_front();
        if (out_word.out_sample !== head_word.out_sample) begin
          $error("out_sample: expected %0d, actual %0d",
                 head_word.out_sample, out_word.out_sample);
          error_count++;
        end
        if (out_word.last_of_run !== head_word.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 head_word.last_of_run, out_word.last_of_run);
          error_count++;
        end
      end
    end
  end

  // Out of reset the step is 1.0 in mono, so each later frame reproduces
  // itself. Full-scale swings check the widest deltas, and the right sample
  // must have no effect.
  task automatic test_reset_state();
    send_frame(make_frame(0, 1234));
    send_frame(make_frame(32767, -1));
    send_frame(make_frame(-32768, 5));
    send_frame(make_frame(32767, 0));
    send_frame(make_frame(-1, 32767));
  endtask

  // Stereo averaging, including odd negative sums that must truncate toward
  // zero. Switching the mode does not restart the converter.
  task automatic test_stereo_average();
    wait_drained();
    write_reg(lirs_pkg::CFG_STEREO_MODE, 64'd1);
    send_frame(make_frame(-3, 0));
    send_frame(make_frame(32767, 32767));
    send_frame(make_frame(-32768, -32768));
    send_frame(make_frame(-32768, 32767));
    send_frame(make_frame(7, -2));
  endtask

  // The step at both ends of its range and beyond: a zero step that acts as
  // the smallest unit, the largest 34-bit step where frames yield nothing,
  // and a tiny step where the word cap cuts runs short.
  task automatic test_step_extremes();
    wait_drained();
    write_reg(lirs_pkg::CFG_STEREO_MODE, 64'd0);
    write_reg(lirs_pkg::CFG_PHASE_STEP, StepLow);
    send_frame(make_frame(-32768, 0));
    send_frame(make_frame(32767, 0));
    send_frame(make_frame(-20000, 0));
    wait_drained();
    write_reg(lirs_pkg::CFG_PHASE_STEP, StepHigh);
    send_frame(make_frame(100, 0));
    send_frame(make_frame(-32768, 0));
    send_frame(make_frame(32767, 0));
    send_frame(make_frame(-5, 0));
    wait_drained();
    write_reg(lirs_pkg::CFG_PHASE_STEP, 64'd0);
    send_frame(make_frame(-32768, 0));
    send_frame(make_frame(32767, 0));
    wait_drained();
    write_reg(lirs_pkg::CFG_PHASE_STEP, StepMask);
    send_frame(make_frame(32767, 0));
    send_frame(make_frame(-32768, 0));
    send_frame(make_frame(1, 0));
    wait_drained();
    write_reg(lirs_pkg::CFG_PHASE_STEP, 64'd1000);
    send_frame(make_frame(32767, 0));
    send_frame(make_frame(-32768, 0));
  endtask

  // Random frames under one idling pattern. The step is mostly drawn from the
  // programmed range, sometimes from the full 34 bits, and sometimes so small
  // that the word cap kicks in. Now and then the sender waits for the block
  // to empty completely before going on.
  task automatic test_random(input int sender_idle, input int receiver_stall, input int count);
    int                 pick;
    longint unsigned    step;
    lirs_pkg::in_word_t frame;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        wait_drained();
        pick = $urandom_range(9);
        if (pick < 7) begin
          step = StepLow + ({$urandom, $urandom} % (StepHigh - StepLow + 64'd1));
        end else if (pick < 9) begin
          step = {$urandom, $urandom} & StepMask;
        end else begin
          step = $urandom_range(1073741824);
        end
        write_reg(lirs_pkg::CFG_PHASE_STEP, step);
        if ($urandom_range(1) == 1) begin
          write_reg(lirs_pkg::CFG_STEREO_MODE, $urandom_range(1));
        end
      end else if ($urandom_range(29) == 0) begin
        wait_drained();
      end
      frame = lirs_pkg::in_word_t'($urandom);
      if ($urandom_range(15) == 0) begin
        frame.left_sample = ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
      end
      send_frame(frame);
    end
    wait_drained();
  endtask

  initial begin
    // Shadow state matches what reset leaves in the block.
    shadow_step = OneQ32;
    shadow_stereo = 1'b0;
    shadow_started = 1'b0;
    shadow_prev = 0;
    shadow_phase = 64'd0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_stereo_average();
    test_step_extremes();
    test_random(0, 0, 60);
    test_random(59, 0, 60);
    test_random(0, 59, 60);
    test_random(37, 37, 60);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
